// ===== src/ias_pkg.sv =====
// Shared types, constants and codes for the insertable array store.
// Has no dependencies; every other file in src imports it.
package ias_pkg;

   // Storage size and the widths that follow from it.
   localparam int CAPACITY   = 64;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);

   // Fixed field widths of the request and response transactions.
   localparam int ACT_W      = 2;
   localparam int POS_W      = 7;
   localparam int DATA_W     = 32;
   localparam int CNT_OUT_W  = 7;
   localparam int ST_W       = 2;

   // Width wide enough to compare a position against the count without loss.
   localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

   // Read-back tree: cells are OR-combined in registered groups.
   localparam int GROUP_SIZE = 8;
   localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

   // Packed stream widths, rounded up to whole bytes.
   localparam int REQ_BITS   = ACT_W + POS_W + DATA_W;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS   = DATA_W + CNT_OUT_W + ST_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   // Request actions.
   localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
   localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

   // Response status codes.
   localparam logic [ST_W-1:0] ST_OK     = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
   localparam logic [ST_W-1:0] ST_BADPOS = 2'd2;

   // Control broadcast from the top level to every cell in the chain.
   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [CMP_W-1:0]  pos;
      logic [DATA_W-1:0] value;
   } cell_ctrl_type;

endpackage

// ===== src/ias_cell.sv =====
// One storage cell of the insertable array chain.
// Depends on ias_pkg for the control struct and widths.
module ias_cell (
   input  logic                        clock,
   input  logic [ias_pkg::CMP_W-1:0]   cell_index,
   input  ias_pkg::cell_ctrl_type      ctrl,
   input  logic [ias_pkg::DATA_W-1:0]  left_data,
   output logic [ias_pkg::DATA_W-1:0]  entry,
   output logic [ias_pkg::DATA_W-1:0]  rd_data
);
   import ias_pkg::*;

   logic [DATA_W-1:0] entry_ff;
   logic [DATA_W-1:0] entry_in;

   // Cells above the write position take their left neighbor's entry;
   // the cell at the write position takes the new value.
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.wr_en) begin
         if (cell_index > ctrl.pos) begin
            entry_in = left_data;
         end else if (cell_index == ctrl.pos) begin
            entry_in = ctrl.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry   = entry_ff;
   assign rd_data = (ctrl.rd_en && (cell_index == ctrl.pos)) ? entry_ff : '0;

endmodule

// ===== src/ias_read_tree.sv =====
// Registered OR tree that collects the one selected cell word for a read.
// Depends on ias_pkg for capacity and group sizing.
module ias_read_tree (
   input  logic                        clock,
   input  logic                        load,
   input  logic [ias_pkg::DATA_W-1:0]  words [ias_pkg::CAPACITY],
   output logic [ias_pkg::DATA_W-1:0]  word
);
   import ias_pkg::*;

   logic [DATA_W-1:0] group_ff [NUM_GROUPS];
   logic [DATA_W-1:0] group_in [NUM_GROUPS];

   genvar g;
   generate
      for (g = 0; g < NUM_GROUPS; g++) begin : gen_group
         always_comb begin
            group_in[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++) begin
               if (g * GROUP_SIZE + k < CAPACITY) begin
                  group_in[g] = group_in[g] | words[IDX_W'(g * GROUP_SIZE + k)];
               end
            end
         end

         always_ff @(posedge clock) begin
            if (load) begin
               group_ff[g] <= group_in[g];
            end
         end
      end
   endgenerate

   // Unselected cells drive zero, so the OR of the groups is the read word.
   always_comb begin
      word = '0;
      for (int j = 0; j < NUM_GROUPS; j++) begin
         word = word | group_ff[GRP_W'(j)];
      end
   end

endmodule

// ===== src/insertable_array_store_top.sv =====
// Insertable array store: an ordered array held in a chain of cells.
// A request is registered in stage A, then in stage B, then in the output register.
// The decode stage and the read-back tree stage together hold one request at a
// time; a new request is taken only as the last one leaves stage B or once it is empty.
// Reset (synchronous, active high) empties the array and clears all valids.
module insertable_array_store_top (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: action [1:0], position [8:2], value [40:9], zero fill above.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ias_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // rsp_tdata: read_value [31:0], element_count [38:32], status [40:39],
   // zero fill above.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ias_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import ias_pkg::*;

   // ------------------------------------------------------------------
   // Stage A: the accepted request, decoded against the current count.
   // ------------------------------------------------------------------
   logic               a_valid_ff, a_valid_in;
   logic [ACT_W-1:0]   a_act_ff;
   logic [POS_W-1:0]   a_pos_ff;
   logic [DATA_W-1:0]  a_value_ff;

   // Stage B: status and count wait here while the read tree settles.
   logic               b_valid_ff, b_valid_in;
   logic [ST_W-1:0]    b_status_ff;
   logic [CNT_W-1:0]   b_count_ff;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]  rsp_value_ff;
   logic [CNT_W-1:0]   rsp_count_ff;
   logic [ST_W-1:0]    rsp_status_ff;

   // Element count.
   logic [CNT_W-1:0]   count_ff, count_in;

   logic               req_fire;
   logic               b_done;
   logic [CMP_W-1:0]   pos_ext;
   logic [CMP_W-1:0]   cnt_ext;
   logic [CMP_W-1:0]   wr_pos;
   logic               is_write;
   logic               is_read;
   logic               full;
   logic               write_ok;
   logic               read_ok;
   logic [ST_W-1:0]    a_status;
   cell_ctrl_type      ctrl;
   logic [DATA_W-1:0]  read_word;

   // Stage B drains when the output register is empty or being emptied.
   assign b_done     = !rsp_valid_ff || rsp_tready;
   // A request is taken when stage A is free and stage B is leaving or empty.
   assign req_tready = !a_valid_ff && (!b_valid_ff || b_done);
   assign req_fire   = req_tvalid && req_tready;

   // Decode of the request held in stage A.
   assign pos_ext  = CMP_W'(a_pos_ff);
   assign cnt_ext  = CMP_W'(count_ff);
   assign is_write = (a_act_ff == ACT_INSERT) || (a_act_ff == ACT_APPEND);
   assign is_read  = (a_act_ff == ACT_READ);
   assign full     = (count_ff == CNT_W'(CAPACITY));
   // An append writes at the current end of the array.
   assign wr_pos   = (a_act_ff == ACT_APPEND) ? cnt_ext : pos_ext;
   assign write_ok = a_valid_ff && is_write && !full && (wr_pos <= cnt_ext);
   assign read_ok  = a_valid_ff && is_read && (pos_ext < cnt_ext);

   // The full check takes priority over the position check.
   always_comb begin
      a_status = ST_OK;
      if (is_write) begin
         if (full) begin
            a_status = ST_FULL;
         end else if (wr_pos > cnt_ext) begin
            a_status = ST_BADPOS;
         end
      end else if (is_read) begin
         if (pos_ext >= cnt_ext) begin
            a_status = ST_BADPOS;
         end
      end
   end

   assign ctrl.wr_en = write_ok;
   assign ctrl.rd_en = read_ok;
   assign ctrl.pos   = write_ok ? wr_pos : pos_ext;
   assign ctrl.value = a_value_ff;

   assign count_in = write_ok ? count_ff + CNT_W'(1) : count_ff;

   // ------------------------------------------------------------------
   // Chain of cells: each cell passes its entry to its right neighbor.
   // ------------------------------------------------------------------
   logic [DATA_W-1:0] cell_entry [CAPACITY];
   logic [DATA_W-1:0] cell_rd    [CAPACITY];

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : gen_cell
         if (i == 0) begin : gen_first
            // The first cell never shifts; its left input is the new value.
            ias_cell u_cell (
               .clock      (clock),
               .cell_index (CMP_W'(i)),
               .ctrl       (ctrl),
               .left_data  (ctrl.value),
               .entry      (cell_entry[i]),
               .rd_data    (cell_rd[i])
            );
         end else begin : gen_rest
            ias_cell u_cell (
               .clock      (clock),
               .cell_index (CMP_W'(i)),
               .ctrl       (ctrl),
               .left_data  (cell_entry[i-1]),
               .entry      (cell_entry[i]),
               .rd_data    (cell_rd[i])
            );
         end
      end
   endgenerate

   // The entry of the last cell falls off the chain on a shift; this only
   // happens when that cell lies beyond the count.
   ias_read_tree u_read_tree (
      .clock (clock),
      .load  (a_valid_ff),
      .words (cell_rd),
      .word  (read_word)
   );

   // ------------------------------------------------------------------
   // Pipeline control.
   // ------------------------------------------------------------------
   assign a_valid_in   = req_fire;
   // Stage A always moves on: stage B was made free when it was loaded.
   assign b_valid_in   = a_valid_ff || (b_valid_ff && !b_done);
   assign rsp_valid_in = (b_valid_ff && b_done) || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_act_ff   <= req_tdata[ACT_W-1:0];
         a_pos_ff   <= req_tdata[ACT_W +: POS_W];
         a_value_ff <= req_tdata[ACT_W + POS_W +: DATA_W];
      end
      if (a_valid_ff) begin
         b_status_ff <= a_status;
         b_count_ff  <= count_in;
      end
      if (b_valid_ff && b_done) begin
         rsp_value_ff  <= read_word;
         rsp_count_ff  <= b_count_ff;
         rsp_status_ff <= b_status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_status_ff, CNT_OUT_W'(rsp_count_ff), rsp_value_ff});

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count exceeds capacity");

   a_single_flight : assert property (@(posedge clock) disable iff (reset)
      !(a_valid_ff && b_valid_ff))
      else $error("decode and read-back stages hold requests at once");

   a_stage_advance : assert property (@(posedge clock) disable iff (reset)
      a_valid_ff |=> b_valid_ff)
      else $error("decoded request did not reach the read-back stage");

   a_reject_holds_count : assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && (a_status != ST_OK)) |=> $stable(count_ff))
      else $error("rejected request changed the element count");

   a_read_zero_on_reject : assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && (b_status_ff != ST_OK)) |-> (read_word == '0))
      else $error("rejected request produced nonzero read data");

endmodule
